// File: rtl/elapsed_timer_bank_unit_macros.svh
// ----------------------------------------------------------------------------
// Elapsed timer bank assertion macros
// Shared concurrent assertion forms, sampled on clk, held off during rst.
// ----------------------------------------------------------------------------
`ifndef ELAPSED_TIMER_BANK_UNIT_MACROS_SVH
`define ELAPSED_TIMER_BANK_UNIT_MACROS_SVH

// condition holds at every edge
`define ETB_ASSERT_ALWAYS(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define ETB_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/etb_pkg.sv
// ----------------------------------------------------------------------------
// Elapsed timer bank package
// Shared constants, request and result codes, and the chain token types.
// ----------------------------------------------------------------------------
package etb_pkg;

  localparam int TIMER_SLOTS = 16;

  localparam int COUNT_W = 24;
  localparam int STAMP_W = 32;
  localparam int ID_W    = 16;
  localparam int REQ_W   = 3;
  localparam int IDX_W   = 4;
  localparam int CODE_W  = 2;
  localparam int STALE_W = 8;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = {COUNT_W{1'b1}};
  localparam logic [STALE_W-1:0] STALE_RESET = 8'd10;

  localparam logic [REQ_W-1:0] REQ_LOAD  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_ZERO  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_START = 3'd2;
  localparam logic [REQ_W-1:0] REQ_STOP  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_TICK  = 3'd4;

  localparam logic [CODE_W-1:0] RC_OK        = 2'd0;
  localparam logic [CODE_W-1:0] RC_NOT_FOUND = 2'd1;
  localparam logic [CODE_W-1:0] RC_EXPIRED   = 2'd2;
  localparam logic [CODE_W-1:0] RC_DONE      = 2'd3;

  typedef struct packed {
    logic               valid;
    logic [REQ_W-1:0]   req;
    logic [ID_W-1:0]    id;
    logic [STAMP_W-1:0] now;
    logic [COUNT_W-1:0] init_count;
    logic [COUNT_W-1:0] init_limit;
    logic [STAMP_W-1:0] init_stamp;
    logic               init_active;
    logic               init_used;
    logic               load_pend;
    logic [IDX_W-1:0]   load_left;
    logic               found;
  } etb_token_t;

  typedef struct packed {
    logic            expire;
    logic [ID_W-1:0] id;
  } etb_hit_t;

endpackage

// File: rtl/etb_cell.sv
// ----------------------------------------------------------------------------
// Elapsed timer bank slot cell
// Holds one timer slot, serves the request token passing through it and
// hands the updated token to the next cell.
// ----------------------------------------------------------------------------
module etb_cell
  import etb_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  logic [STALE_W-1:0] stale_limit,
  input  etb_token_t         tok_in,
  output etb_token_t         tok_out,
  output etb_hit_t           hit
);

  etb_token_t         tok;
  logic [ID_W-1:0]    key;
  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] limit;
  logic [STAMP_W-1:0] stamp;
  logic               running;
  logic               used;

  logic [STAMP_W-1:0] diff;
  logic [STAMP_W:0]   sum;
  logic [COUNT_W-1:0] nv_sat;
  logic [COUNT_W-1:0] nv;
  logic               expire;
  logic               is_tick;
  logic               first_run;
  logic               moves;
  logic               lookup_hit;
  logic               load_hit;

  always_comb begin
    diff   = tok.now - stamp;
    sum    = {{(STAMP_W+1-COUNT_W){1'b0}}, count} + {1'b0, diff};
    nv_sat = (sum >= {{(STAMP_W+1-COUNT_W){1'b0}}, COUNT_MAX}) ? COUNT_MAX
                                                               : sum[COUNT_W-1:0];
    nv     = (diff >= {{(STAMP_W-STALE_W){1'b0}}, stale_limit}) ? '0 : nv_sat;
    expire = (nv >= limit);

    is_tick    = tok.valid && (tok.req == REQ_TICK) && used && running;
    first_run  = (stamp == '0);
    moves      = is_tick && !first_run && (diff != '0);
    lookup_hit = tok.valid && (tok.req inside {REQ_ZERO, REQ_START, REQ_STOP}) &&
                 !tok.found && used && (key == tok.id);
    load_hit   = tok.valid && (tok.req == REQ_LOAD) && tok.load_pend &&
                 (tok.load_left == '0);

    hit.expire = moves && expire;
    hit.id     = (moves && expire) ? key : '0;

    tok_out = tok;
    if (lookup_hit) begin
      tok_out.found = 1'b1;
    end
    if (tok.load_pend) begin
      if (tok.load_left == '0) begin
        tok_out.load_pend = 1'b0;
      end else begin
        tok_out.load_left = tok.load_left - IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
      key       <= '0;
      count     <= '0;
      limit     <= '0;
      stamp     <= '0;
      used      <= 1'b0;
      running   <= 1'b0;
    end else if (adv) begin
      tok <= tok_in;
      if (load_hit) begin
        key     <= tok.id;
        count   <= tok.init_count;
        limit   <= tok.init_limit;
        stamp   <= tok.init_stamp;
        running <= tok.init_active;
        used    <= tok.init_used;
      end else if (lookup_hit) begin
        count <= '0;
        stamp <= tok.now;
        if (tok.req == REQ_START) begin
          running <= 1'b1;
        end else if (tok.req == REQ_STOP) begin
          running <= 1'b0;
        end
      end else if (is_tick) begin
        if (first_run) begin
          count <= {{(COUNT_W-1){1'b0}}, 1'b1};
          stamp <= tok.now;
        end else if (moves) begin
          count <= expire ? '0 : nv;
          stamp <= tok.now;
        end
      end
    end
  end

endmodule

// File: rtl/elapsed_timer_bank_unit.sv
// ----------------------------------------------------------------------------
// Elapsed timer bank
// Bank of timer slots kept in a row of cells; each request walks the row as
// a token, one cell per cycle unless the row is held, then closes with a final result.
//
//   channel  dir  handshake           payload
//   s_*      in   s_tvalid/s_tready   tuser request kind, tdata request fields
//   m_*      out  m_tvalid/m_tready   tdata code and id, tlast end of request
//   cfg_*    in   cfg_valid/cfg_ready cfg_data stale limit
//
// From transfer to final result a request passes through every slot cell in
// the row, the tail stage and the output register. Each expired result that
// meets a full output register holds the whole row until it is taken. A new
// request is taken once the final result of the previous one has moved to the
// output register. Reset clears all slots.
// ----------------------------------------------------------------------------
`include "elapsed_timer_bank_unit_macros.svh"

module elapsed_timer_bank_unit
  import etb_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [2:0]   s_tuser,  // req_type
  // slot_index, timer_id, now_seconds, init_count, init_limit, init_stamp,
  // init_active, init_used, zero fill
  input  logic [135:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [23:0]  m_tdata,  // result_code, expired_id, zero fill
  output logic         m_tlast,  // last_of_run
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [7:0]   cfg_data  // stale_limit
);

  etb_token_t         chain [TIMER_SLOTS+1];
  etb_hit_t           hits  [TIMER_SLOTS];
  etb_token_t         tail;
  logic [STALE_W-1:0] stale_limit;
  logic               busy;
  logic               accept;
  logic               out_free;
  logic               emit_any;
  logic [ID_W-1:0]    emit_id;
  logic               adv;
  logic [CODE_W-1:0]  final_code;
  logic [CODE_W-1:0]  out_code;
  logic [ID_W-1:0]    out_id;
  logic               out_last;
  logic [TIMER_SLOTS:0] tok_valid;

  assign cfg_ready = 1'b1;
  assign s_tready  = !busy;
  assign accept    = s_tvalid && s_tready;
  assign out_free  = !m_tvalid || m_tready;
  assign adv       = !emit_any || out_free;

  always_comb begin
    chain[0].valid       = accept;
    chain[0].req         = s_tuser;
    chain[0].load_left   = s_tdata[3:0];
    chain[0].id          = s_tdata[19:4];
    chain[0].now         = s_tdata[51:20];
    chain[0].init_count  = s_tdata[75:52];
    chain[0].init_limit  = s_tdata[99:76];
    chain[0].init_stamp  = s_tdata[131:100];
    chain[0].init_active = s_tdata[132];
    chain[0].init_used   = s_tdata[133];
    chain[0].load_pend   = (s_tuser == REQ_LOAD);
    chain[0].found       = 1'b0;
  end

  for (genvar i = 0; i < TIMER_SLOTS; i++) begin : g_cell
    etb_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .adv         (adv),
      .stale_limit (stale_limit),
      .tok_in      (chain[i]),
      .tok_out     (chain[i+1]),
      .hit         (hits[i])
    );
    assign tok_valid[i] = chain[i+1].valid;
  end
  assign tok_valid[TIMER_SLOTS] = tail.valid;

  always_comb begin
    emit_any = 1'b0;
    emit_id  = '0;
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      emit_any = emit_any | hits[i].expire;
      emit_id  = emit_id | hits[i].id;
    end
  end

  always_comb begin
    case (tail.req)
      REQ_ZERO, REQ_START, REQ_STOP: final_code = tail.found ? RC_OK : RC_NOT_FOUND;
      REQ_TICK:                      final_code = RC_DONE;
      default:                       final_code = RC_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stale_limit <= STALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      stale_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tail.valid <= 1'b0;
    end else if (tail.valid) begin
      if (out_free) begin
        tail.valid <= 1'b0;
      end
    end else if (adv) begin
      tail <= chain[TIMER_SLOTS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (tail.valid && out_free) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_free) begin
      if (emit_any) begin
        m_tvalid <= 1'b1;
        out_code <= RC_EXPIRED;
        out_id   <= emit_id;
        out_last <= 1'b0;
      end else if (tail.valid) begin
        m_tvalid <= 1'b1;
        out_code <= final_code;
        out_id   <= '0;
        out_last <= 1'b1;
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

  assign m_tdata = {6'b0, out_id, out_code};
  assign m_tlast = out_last;

  `ETB_ASSERT_ALWAYS(a_one_token, $countones(tok_valid) <= 1, "more than one token in row")
  `ETB_ASSERT_ALWAYS(a_idle_empty, busy || (tok_valid == '0), "token present while idle")
  `ETB_ASSERT_NEXT(a_accept_enters, accept, chain[1].valid, "accepted request not in first cell")
  `ETB_ASSERT_ALWAYS(a_emit_busy, !emit_any || busy, "expired result while idle")

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Elapsed timer bank testbench
// Drives load, zero, start, stop and tick requests into the timer bank and
// checks every result against a slot-level predictor kept in the bench.
// Directed cases cover the field extremes and the tick corner cases. Random
// phases follow, run under several stale limits, with bursty stalls on both
// streams in all but the last phase.
// ----------------------------------------------------------------------------
module tb;
  import etb_pkg::*;

  localparam int CYCLE_LIMIT = 800000;
  localparam int PHASE_ITEMS = 110;

  typedef struct {
    logic [REQ_W-1:0]   kind;
    logic [IDX_W-1:0]   slot;
    logic [ID_W-1:0]    id;
    logic [STAMP_W-1:0] now;
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] limit;
    logic [STAMP_W-1:0] stamp;
    logic               active;
    logic               used;
  } timer_req_t;

  typedef struct {
    logic [CODE_W-1:0] code;
    logic [ID_W-1:0]   id;
    logic              last;
  } timer_reply_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [2:0]   s_tuser = '0;   // req_type
  // slot_index, timer_id, now_seconds, init_count, init_limit, init_stamp,
  // init_active, init_used, zero fill
  logic [135:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [23:0]  m_tdata;        // result_code, expired_id, zero fill
  logic         m_tlast;        // last_of_run
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [7:0]   cfg_data = '0;  // stale_limit

  // predicted bank contents
  logic [ID_W-1:0]    slot_key     [TIMER_SLOTS];
  logic [COUNT_W-1:0] slot_count   [TIMER_SLOTS];
  logic [COUNT_W-1:0] slot_limit   [TIMER_SLOTS];
  logic [STAMP_W-1:0] slot_stamp   [TIMER_SLOTS];
  logic               slot_running [TIMER_SLOTS];
  logic               slot_used    [TIMER_SLOTS];
  logic [STALE_W-1:0] stale_secs = STALE_RESET;

  timer_reply_t expected_replies[$];

  int unsigned cycles = 0;
  int requests_sent = 0;
  int replies_checked = 0;
  int expiries_seen = 0;
  int busiest_tick = 0;
  int mismatches = 0;
  int stall_left = 0;
  bit steady = 1'b0;
  logic [STAMP_W-1:0] wall = 32'd2000;
  logic [ID_W-1:0] id_pool[8];

  elapsed_timer_bank_unit dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_replies.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_clear
    initial begin
      slot_key[g]     = '0;
      slot_count[g]   = '0;
      slot_limit[g]   = '0;
      slot_stamp[g]   = '0;
      slot_running[g] = 1'b0;
      slot_used[g]    = 1'b0;
    end
  end

  function automatic void push_reply(logic [CODE_W-1:0] code, logic [ID_W-1:0] id,
                                     logic last);
    timer_reply_t e;
    e.code = code;
    e.id   = id;
    e.last = last;
    expected_replies.push_back(e);
  endfunction

  // applies one accepted request to the bank copy and queues its results
  function automatic void advance_bank(timer_req_t r);
    int hit;
    int fired;
    logic [STAMP_W-1:0] gap;
    logic [COUNT_W:0]   sum;
    logic [COUNT_W-1:0] nv;
    hit = -1;
    fired = 0;
    case (r.kind)
      REQ_LOAD: begin
        slot_key[r.slot]     = r.id;
        slot_count[r.slot]   = r.count;
        slot_limit[r.slot]   = r.limit;
        slot_stamp[r.slot]   = r.stamp;
        slot_running[r.slot] = r.active;
        slot_used[r.slot]    = r.used;
        push_reply(RC_OK, '0, 1'b1);
      end
      REQ_ZERO, REQ_START, REQ_STOP: begin
        for (int i = 0; i < TIMER_SLOTS; i++)
          if (hit < 0 && slot_used[i] && slot_key[i] == r.id) hit = i;
        if (hit < 0) begin
          push_reply(RC_NOT_FOUND, '0, 1'b1);
        end else begin
          slot_count[hit] = '0;
          slot_stamp[hit] = r.now;
          if (r.kind == REQ_START) slot_running[hit] = 1'b1;
          if (r.kind == REQ_STOP) slot_running[hit] = 1'b0;
          push_reply(RC_OK, '0, 1'b1);
        end
      end
      REQ_TICK: begin
        for (int i = 0; i < TIMER_SLOTS; i++) begin
          if (!slot_used[i] || !slot_running[i]) continue;
          if (slot_stamp[i] == '0) begin
            slot_count[i] = COUNT_W'(1);
            slot_stamp[i] = r.now;
            continue;
          end
          gap = r.now - slot_stamp[i];
          if (gap == '0) continue;
          if (gap >= COUNT_MAX) begin
            nv = COUNT_MAX;
          end else begin
            sum = {1'b0, slot_count[i]} + {1'b0, gap[COUNT_W-1:0]};
            nv = (sum >= COUNT_MAX) ? COUNT_MAX : sum[COUNT_W-1:0];
          end
          if (gap >= stale_secs) nv = '0;
          if (nv >= slot_limit[i]) begin
            push_reply(RC_EXPIRED, slot_key[i], 1'b0);
            fired++;
            nv = '0;
          end
          slot_count[i] = nv;
          slot_stamp[i] = r.now;
        end
        push_reply(RC_DONE, '0, 1'b1);
        expiries_seen += fired;
        if (fired + 1 > busiest_tick) busiest_tick = fired + 1;
      end
      default: push_reply(RC_OK, '0, 1'b1);
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch at cycle %0d: %s got %0h expected %0h", cycles, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    timer_reply_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_replies.size() == 0) begin
        report_mismatch("unexpected result, code", 32'(m_tdata[1:0]), 'x);
      end else begin
        e = expected_replies.pop_front();
        replies_checked++;
        if (m_tdata[1:0] !== e.code)
          report_mismatch("result_code", 32'(m_tdata[1:0]), 32'(e.code));
        if (m_tdata[17:2] !== e.id)
          report_mismatch("expired_id", 32'(m_tdata[17:2]), 32'(e.id));
        if (m_tlast !== e.last)
          report_mismatch("last_of_run", 32'(m_tlast), 32'(e.last));
      end
    end
  end

  always @(negedge clk) begin
    if (rst || steady) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 15) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_request(timer_req_t r);
    @(negedge clk);
    if (!steady && $urandom_range(0, 4) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(negedge clk);
    end
    s_tuser  <= r.kind;
    s_tdata  <= {2'b00, r.used, r.active, r.stamp, r.limit, r.count, r.now, r.id, r.slot};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    advance_bank(r);
    requests_sent++;
  endtask

  // drop the request stream and let the bank drain completely
  task automatic settle();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (expected_replies.size() != 0) @(posedge clk);
    repeat (TIMER_SLOTS + 4) @(posedge clk);
  endtask

  task automatic write_stale(logic [STALE_W-1:0] secs);
    settle();
    @(negedge clk);
    cfg_data  <= secs;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    stale_secs = secs;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic timer_req_t blank_request(logic [REQ_W-1:0] kind);
    timer_req_t r;
    r.kind   = kind;
    r.slot   = IDX_W'($urandom);
    r.id     = ID_W'($urandom);
    r.now    = $urandom;
    r.count  = COUNT_W'($urandom);
    r.limit  = COUNT_W'($urandom);
    r.stamp  = $urandom;
    r.active = 1'($urandom);
    r.used   = 1'($urandom);
    return r;
  endfunction

  task automatic load_slot(logic [IDX_W-1:0] slot, logic [ID_W-1:0] id,
                           logic [COUNT_W-1:0] count, logic [COUNT_W-1:0] limit,
                           logic [STAMP_W-1:0] stamp, logic active, logic used);
    timer_req_t r;
    r = blank_request(REQ_LOAD);
    r.slot   = slot;
    r.id     = id;
    r.count  = count;
    r.limit  = limit;
    r.stamp  = stamp;
    r.active = active;
    r.used   = used;
    send_request(r);
  endtask

  task automatic lookup(logic [REQ_W-1:0] kind, logic [ID_W-1:0] id,
                        logic [STAMP_W-1:0] now);
    timer_req_t r;
    r = blank_request(kind);
    r.id  = id;
    r.now = now;
    send_request(r);
  endtask

  task automatic tick(logic [STAMP_W-1:0] now);
    timer_req_t r;
    r = blank_request(REQ_TICK);
    r.now = now;
    send_request(r);
  endtask

  // wall clock mostly creeps forward, with rare large jumps and steps back
  function automatic logic [STAMP_W-1:0] next_now();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick == 0) wall = $urandom;
    else if (pick == 1) wall = wall - $urandom_range(1, 20);
    else if (pick < 16) wall = wall + $urandom_range(0, 3);
    else wall = wall + $urandom_range(4, 300);
    return wall;
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    return ($urandom_range(0, 9) != 0) ? id_pool[$urandom_range(0, 7)] :
                                         ID_W'($urandom);
  endfunction

  task automatic load_random_slot();
    logic [COUNT_W-1:0] count;
    logic [COUNT_W-1:0] limit;
    logic [STAMP_W-1:0] stamp;
    int pick;
    count = $urandom_range(0, 1) ? COUNT_W'($urandom_range(0, 20)) : COUNT_W'($urandom);
    pick = $urandom_range(0, 19);
    if (pick < 12) limit = COUNT_W'($urandom_range(0, 40));
    else if (pick < 17) limit = COUNT_W'($urandom);
    else limit = '0;
    pick = $urandom_range(0, 9);
    if (pick < 5) stamp = wall - $urandom_range(0, 5);
    else if (pick < 7) stamp = '0;
    else stamp = $urandom;
    load_slot(IDX_W'($urandom), pick_id(), count, limit, stamp,
              $urandom_range(0, 3) != 0, $urandom_range(0, 6) != 0);
  endtask

  // every slot running with a tiny limit, so the next tick reports many expiries
  task automatic fill_bank();
    logic [COUNT_W-1:0] limit;
    limit = $urandom_range(0, 1) ? '0 : COUNT_W'($urandom_range(0, 3));
    for (int i = 0; i < TIMER_SLOTS; i++)
      load_slot(IDX_W'(i), id_pool[$urandom_range(0, 7)], COUNT_W'($urandom_range(0, 3)),
                limit, wall, 1'b1, 1'b1);
    tick(next_now());
  endtask

  task automatic test_lookups();
    load_slot(4'd0, 16'hFFFF, COUNT_MAX, COUNT_MAX, 32'hFFFF_FFFF, 1'b0, 1'b1);
    load_slot(4'd15, 16'h0000, '0, 24'd6, '0, 1'b0, 1'b1);
    load_slot(4'd7, 16'h1234, 24'd3, 24'd9, 32'd40, 1'b1, 1'b0);
    load_slot(4'd9, 16'hFFFF, 24'd2, 24'd100, '0, 1'b1, 1'b1);
    lookup(REQ_ZERO, 16'h1234, 32'd50);
    lookup(REQ_ZERO, 16'hFFFF, '0);
    lookup(REQ_START, 16'h0000, '0);
    lookup(REQ_STOP, 16'hFFFF, 32'hFFFF_FFFF);
    lookup(REQ_START, 16'hFFFF, 32'd1);
    lookup(REQ_STOP, 16'h4321, 32'd2);
  endtask

  task automatic test_tick_paths();
    tick(32'd5);
    tick(32'd5);
    tick(32'd8);
    tick(32'd10);
    tick(32'd3);
    load_slot(4'd1, 16'hAAAA, '0, '0, 32'd100, 1'b1, 1'b1);
    tick(32'd101);
  endtask

  task automatic test_saturation();
    write_stale(8'd255);
    load_slot(4'd2, 16'h5555, 24'hFFFFF0, COUNT_MAX, 32'd1000, 1'b1, 1'b1);
    tick(32'd1200);
    write_stale(8'd1);
    tick(32'd1201);
    tick(32'd1203);
  endtask

  task automatic test_random(int n, logic [STALE_W-1:0] secs);
    int first;
    int pick;
    write_stale(secs);
    foreach (id_pool[i]) id_pool[i] = ID_W'($urandom);
    id_pool[0] = '0;
    id_pool[1] = '1;
    first = requests_sent;
    while (requests_sent - first < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) fill_bank();
      else if (pick < 28) load_random_slot();
      else if (pick < 38) lookup(REQ_ZERO, pick_id(), next_now());
      else if (pick < 53) lookup(REQ_START, pick_id(), next_now());
      else if (pick < 62) lookup(REQ_STOP, pick_id(), next_now());
      else tick(next_now());
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_lookups();
    test_tick_paths();
    test_saturation();
    test_random(PHASE_ITEMS, 8'd1);
    test_random(PHASE_ITEMS, 8'd255);
    test_random(PHASE_ITEMS, STALE_W'($urandom_range(2, 254)));
    steady = 1'b1;
    test_random(PHASE_ITEMS, STALE_RESET);
    settle();
    $display("%0d requests under several stale limits, %0d results checked",
             requests_sent, replies_checked);
    $display("%0d expiry reports, largest tick answer %0d results", expiries_seen,
             busiest_tick);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
